// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the reorder receiver RTL.
// Clock is clk and reset is rst_n in every module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rrca_pkg.sv =====
// Package for the reorder receiver: widths, result codes, entry and result types.
// Used by the control, output buffer and top-level modules.
package rrca_pkg;

    localparam int STORE_DEPTH = 8;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam int SEQ_W   = 31;
    localparam int LEN_W   = 15;
    localparam int TAG_W   = 16;
    localparam int CHUNK_W = 16;
    localparam int NE_W    = 32;
    localparam int OFF_W   = 46;
    localparam int KIND_W  = 3;

    localparam int ENTRY_W     = SEQ_W + LEN_W + TAG_W;
    localparam int S_TDATA_W   = ((ENTRY_W + 7) / 8) * 8;
    localparam int S_PAD_W     = S_TDATA_W - ENTRY_W;
    localparam int RES_DATA_W  = NE_W + OFF_W + LEN_W + TAG_W + OFF_W;
    localparam int M_TDATA_W   = ((RES_DATA_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - RES_DATA_W;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(1024);

    localparam logic IN_KIND_START = 1'b0;
    localparam logic IN_KIND_DATA  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        RES_WRITE      = 3'd0,
        RES_DROP_FULL  = 3'd1,
        RES_DROP_STALE = 3'd2,
        RES_FINAL      = 3'd3,
        RES_ACK        = 3'd4
    } res_kind_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic [SEQ_W-1:0] seq;
    } entry_t;

    typedef struct packed {
        res_kind_t         kind;
        logic [NE_W-1:0]   seq;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  len;
        logic [TAG_W-1:0]  tag;
        logic [OFF_W-1:0]  fsize;
        logic              last;
    } result_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
    } ram_req_t;

endpackage

// ===== rtl/core/rrca_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rrca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rrca_outbuf.sv =====
// Output register of the reorder receiver: holds one result word until taken.
// Depends on rrca_pkg.
module rrca_outbuf
    import rrca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_load,
    input  result_t               res,
    output logic                  out_free,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    output logic [KIND_W-1:0]     m_axis_tuser,
    output logic                  m_axis_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            data_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tlast  = data_reg.last;
    assign m_axis_tdata  = {M_PAD_W'(0), data_reg.fsize, data_reg.tag,
                            data_reg.len, data_reg.offset, data_reg.seq};

endmodule

// ===== rtl/core/rrca_ctrl.sv =====
// Sequencer of the reorder receiver: scans, drains and fills the reorder store.
// Depends on rrca_pkg and assert_macros.svh; drives rrca_ram and rrca_outbuf.
`include "assert_macros.svh"

module rrca_ctrl
    import rrca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CHUNK_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_kind,
    input  entry_t             in_entry,
    input  logic               in_last,
    output logic               res_load,
    output result_t            res,
    input  logic               out_free,
    output ram_req_t           ram_req,
    input  entry_t             ram_rdata
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CALC  = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_WRITE = 10'b0000001000,
        S_DRAIN = 10'b0000010000,
        S_MOVE  = 10'b0000100000,
        S_STALE = 10'b0001000000,
        S_FULL  = 10'b0010000000,
        S_FINAL = 10'b0100000000,
        S_ACK   = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic               started_reg, started_next;
    logic [NE_W-1:0]    ne_reg, ne_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               pend_reg, pend_next;
    logic               drain_reg, drain_next;
    logic [ADDR_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0]  hit_idx_reg, hit_idx_next;
    entry_t             in_reg, in_next;
    logic               in_last_reg, in_last_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    entry_t             hold_reg, hold_next;

    logic [SEQ_W-1:0]         mul_seq;
    logic [SEQ_W+CHUNK_W-1:0] prod;
    logic [NE_W-1:0]          in_seq_ext;
    logic [NE_W-1:0]          target;
    logic [CNT_W-1:0]         cnt_m1;
    logic [ADDR_W-1:0]        last_idx;
    logic                     issue;
    logic                     hit;
    state_t                   post_state;

    assign mul_seq    = (state_reg == S_DRAIN) ? hold_reg.seq : in_reg.seq;
    assign prod       = mul_seq * chunk_reg;
    assign in_seq_ext = {1'b0, in_reg.seq};
    assign target     = drain_reg ? ne_reg : in_seq_ext;
    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign last_idx   = cnt_m1[ADDR_W-1:0];
    assign issue      = (state_reg == S_SCAN) && (scan_idx_reg < cnt_reg);
    assign hit        = pend_reg && ({1'b0, ram_rdata.seq} == target);
    assign post_state = in_last_reg ? S_FINAL : S_ACK;
    assign in_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        chunk_next    = cfg_we ? cfg_wdata : chunk_reg;
        started_next  = started_reg;
        ne_next       = ne_reg;
        cnt_next      = cnt_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = 1'b0;
        drain_next    = drain_reg;
        pend_idx_next = pend_idx_reg;
        hit_idx_next  = hit_idx_reg;
        in_next       = in_reg;
        in_last_next  = in_last_reg;
        off_next      = off_reg;
        hold_next     = hold_reg;

        res_load      = 1'b0;
        res           = '0;
        res.kind      = RES_WRITE;

        ram_req       = '0;
        ram_req.re    = issue;
        ram_req.raddr = scan_idx_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == IN_KIND_START)
                    begin
                        started_next = 1'b1;
                        ne_next      = '0;
                        cnt_next     = '0;
                    end
                    else if (started_reg)
                    begin
                        in_next      = in_entry;
                        in_last_next = in_last;
                        state_next   = S_CALC;
                    end
                end
            end

            S_CALC:
            begin
                off_next      = prod[OFF_W-1:0];
                scan_idx_next = '0;
                drain_next    = 1'b0;
                if (in_seq_ext == ne_reg)
                begin
                    state_next = S_WRITE;
                end
                else if (in_seq_ext < ne_reg)
                begin
                    state_next = S_STALE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    if (drain_reg)
                    begin
                        hold_next    = ram_rdata;
                        hit_idx_next = pend_idx_reg;
                        state_next   = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_STALE;
                    end
                end
                else if (!pend_reg && !issue)
                begin
                    if (drain_reg)
                    begin
                        state_next = post_state;
                    end
                    else if (cnt_reg < CNT_W'(STORE_DEPTH))
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = cnt_reg[ADDR_W-1:0];
                        ram_req.wdata = in_reg;
                        cnt_next      = cnt_reg + CNT_W'(1);
                        state_next    = post_state;
                    end
                    else
                    begin
                        state_next = S_FULL;
                    end
                end
                else
                begin
                    pend_next     = issue;
                    pend_idx_next = scan_idx_reg[ADDR_W-1:0];
                    if (issue)
                    begin
                        scan_idx_next = scan_idx_reg + CNT_W'(1);
                    end
                end
            end

            S_WRITE:
            begin
                if (out_free)
                begin
                    res_load      = 1'b1;
                    res.kind      = RES_WRITE;
                    res.seq       = in_seq_ext;
                    res.offset    = off_reg;
                    res.len       = in_reg.len;
                    res.tag       = in_reg.tag;
                    ne_next       = ne_reg + NE_W'(1);
                    drain_next    = 1'b1;
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end

            S_DRAIN:
            begin
                // fetch the tail entry to fill the hole left by the drained one
                ram_req.re    = 1'b1;
                ram_req.raddr = last_idx;
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res.kind   = RES_WRITE;
                    res.seq    = {1'b0, hold_reg.seq};
                    res.offset = prod[OFF_W-1:0];
                    res.len    = hold_reg.len;
                    res.tag    = hold_reg.tag;
                    state_next = S_MOVE;
                end
            end

            S_MOVE:
            begin
                if (hit_idx_reg != last_idx)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = hit_idx_reg;
                    ram_req.wdata = ram_rdata;
                end
                cnt_next      = cnt_m1;
                ne_next       = ne_reg + NE_W'(1);
                scan_idx_next = '0;
                state_next    = S_SCAN;
            end

            S_STALE,
            S_FULL:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res.kind   = (state_reg == S_STALE) ? RES_DROP_STALE : RES_DROP_FULL;
                    res.seq    = in_seq_ext;
                    res.len    = in_reg.len;
                    res.tag    = in_reg.tag;
                    state_next = post_state;
                end
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res.kind   = RES_FINAL;
                    res.seq    = in_seq_ext;
                    res.fsize  = off_reg + OFF_W'(in_reg.len);
                    state_next = S_ACK;
                end
            end

            S_ACK:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    res.kind   = RES_ACK;
                    res.seq    = ne_reg - NE_W'(1);
                    res.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            chunk_reg    <= CHUNK_RESET;
            started_reg  <= 1'b0;
            ne_reg       <= '0;
            cnt_reg      <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            drain_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chunk_reg    <= chunk_next;
            started_reg  <= started_next;
            ne_reg       <= ne_next;
            cnt_reg      <= cnt_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            drain_reg    <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        in_reg       <= in_next;
        in_last_reg  <= in_last_next;
        off_reg      <= off_next;
        hold_reg     <= hold_next;
    end

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(STORE_DEPTH), "entry count above store depth")
    `ASSERT_ALWAYS(a_ram_one_access, !(ram_req.re && ram_req.we), "store read and write overlap")
    `ASSERT_IMPLY(a_load_free, res_load, out_free, "result loaded into a full output register")
    `ASSERT_IMPLY(a_ne_step, ne_reg != $past(ne_reg), ne_reg == $past(ne_reg) + NE_W'(1) || ne_reg == '0, "expected sequence jumped")

endmodule

// ===== rtl/core/reorder_receiver_cumulative_ack.sv =====
// Reorder receiver with cumulative acknowledgement, top level.
// Instantiates rrca_ctrl, rrca_ram and rrca_outbuf; depends on rrca_pkg.
//
// Input stream (s_axis): tuser is the kind (start or data), tlast the final
// packet flag, tdata the sequence, payload length and payload tag. Output
// stream (m_axis): tuser is the result kind, tlast marks the last result word
// of one input word (always the cumulative ack), tdata the result fields.
// chunk_bytes is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// One input word is taken at a time. A start word, or a data word before
// any start, is handled in the idle state. A data word first forms the byte
// offset, then scans the store and emits its result words; the next word is
// taken the cycle after the ack is loaded. Each drained entry adds a rescan
// up to its slot, a step to emit it and a step to move the tail entry in.
// The scan reads one entry per cycle through the store's registered read
// port. The first result word of an in-order word, or of one behind the
// expected sequence, is loaded from S_WRITE or S_STALE after S_CALC.
// Reset clears the started flag, expected sequence and entry count, and sets
// chunk_bytes to 1024; store contents need no clearing. A stalled receiver
// holds the output word and the result states; idle, it still takes input.
module reorder_receiver_cumulative_ack
    import rrca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CHUNK_W-1:0]   cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // seq[30:0], payload_len[45:31], payload_tag[61:46], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // seq_out[31:0], byte_offset[77:32], length[92:78], tag_out[108:93],
    // file size[154:109], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // result_kind
    output logic [KIND_W-1:0]    m_axis_tuser,
    output logic                 m_axis_tlast
);

    entry_t   in_entry;
    entry_t   ram_rdata;
    ram_req_t ram_req;
    result_t  res;
    logic     res_load;
    logic     out_free;

    assign in_entry = s_axis_tdata[ENTRY_W-1:0];

    rrca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_entry  (in_entry),
        .in_last   (s_axis_tlast),
        .res_load  (res_load),
        .res       (res),
        .out_free  (out_free),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    rrca_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    rrca_outbuf u_outbuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_load      (res_load),
        .res           (res),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
